// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define PIDVL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pidvl check failed");

// Same with a caller-supplied message.
`define PIDVL_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

// ===== rtl/pidvl_pkg.sv =====
// Shared constants and control types of the PID velocity limiter.
// No dependencies.
`default_nettype none
package pidvl_pkg;
	localparam int GAIN_W = 16;
	localparam int LIM_W  = 15;
	localparam int VAL_W  = 16;
	localparam int IDX_W  = 3;
	localparam int MUL_W  = 18;
	localparam int PROD_W = 36;
	localparam int ACC_W  = 38;
	localparam int SQ_W   = 34;
	localparam int ROOT_W = 17;
	localparam int QUO_W  = 16;
	localparam int DEN_W  = 18;

	localparam logic [IDX_W-1:0] REG_KP        = 3'd0;
	localparam logic [IDX_W-1:0] REG_KI        = 3'd1;
	localparam logic [IDX_W-1:0] REG_KD        = 3'd2;
	localparam logic [IDX_W-1:0] REG_VEL_LIM   = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTEG_LIM = 3'd4;
	localparam logic [IDX_W-1:0] REG_MAX_STEP  = 3'd5;

	localparam logic [GAIN_W-1:0] KP_RST        = 16'd4096;
	localparam logic [GAIN_W-1:0] KI_RST        = 16'd0;
	localparam logic [GAIN_W-1:0] KD_RST        = 16'd0;
	localparam logic [LIM_W-1:0]  VEL_LIM_RST   = 15'd768;
	localparam logic [LIM_W-1:0]  INTEG_LIM_RST = 15'd614;
	localparam logic [LIM_W-1:0]  MAX_STEP_RST  = 15'd77;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_op_t;

	typedef struct packed {
		logic    mul_en;
		acc_op_t acc_op;
	} mac_ctl_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} iter_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/pidvl_if.sv =====
// Stream interfaces for the input tick and the command result.
// Depends on nothing but plain logic types.
`default_nettype none
interface pidvl_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] err_east;
	logic signed [15:0] err_north;
	logic signed [15:0] meas_vel_east;
	logic signed [15:0] meas_vel_north;
	logic               clear;
	modport source (output valid, err_east, err_north, meas_vel_east, meas_vel_north,
		clear, input ready);
	modport sink (input valid, err_east, err_north, meas_vel_east, meas_vel_north,
		clear, output ready);
endinterface

interface pidvl_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] cmd_vel_east;
	logic signed [15:0] cmd_vel_north;
	logic               accel_limited;
	modport source (output valid, cmd_vel_east, cmd_vel_north, accel_limited, input ready);
	modport sink (input valid, cmd_vel_east, cmd_vel_north, accel_limited, output ready);
endinterface
`default_nettype wire

// ===== rtl/pidvl_mac.sv =====
// Shared multiplier with product register and accumulator.
// Depends on pidvl_pkg.
`default_nettype none
module pidvl_mac (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pidvl_pkg::mac_ctl_t                ctl,
	input  wire logic signed [pidvl_pkg::MUL_W-1:0] a,
	input  wire logic signed [pidvl_pkg::MUL_W-1:0] b,
	output logic signed [pidvl_pkg::PROD_W-1:0]     prod,
	output logic signed [pidvl_pkg::ACC_W-1:0]      acc
);
	logic signed [pidvl_pkg::PROD_W-1:0] prod_q;
	logic signed [pidvl_pkg::ACC_W-1:0]  acc_q;
	logic signed [pidvl_pkg::ACC_W-1:0]  prod_ext;

	assign prod_ext = pidvl_pkg::ACC_W'(prod_q);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= a * b;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.acc_op)
			pidvl_pkg::ACC_LOAD: acc_q <= prod_ext;
			pidvl_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
			default:             acc_q <= acc_q;
		endcase
	end

	assign prod = prod_q;
	assign acc  = acc_q;

	// arst_n kept on the port for a uniform hookup; datapath only
	logic unused_rst;
	assign unused_rst = arst_n;
endmodule
`default_nettype wire

// ===== rtl/pidvl_iter.sv =====
// Bit-serial square root and restoring divide sharing one subtractor.
// Depends on pidvl_pkg.
`default_nettype none
module pidvl_iter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pidvl_pkg::iter_ctl_t             ctl,
	input  wire logic [pidvl_pkg::SQ_W-1:0]       num,
	input  wire logic [pidvl_pkg::DEN_W-1:0]      den,
	output logic                                  done,
	output logic [pidvl_pkg::ROOT_W-1:0]          root,
	output logic [pidvl_pkg::QUO_W-1:0]           quo
);
	localparam int W = pidvl_pkg::SQ_W + 1;

	logic                          run_q;
	logic                          done_q;
	logic                          mode_q;
	logic [4:0]                    cnt_q;
	logic [W-1:0]                  v_q;
	logic [W-1:0]                  r_q;
	logic [W-1:0]                  bit_q;
	logic [pidvl_pkg::DEN_W-1:0]   den_q;
	logic [W-1:0]                  sub_a;
	logic [W-1:0]                  sub_b;
	logic [W:0]                    diff;
	logic                          ge;

	always_comb begin
		if (mode_q) begin
			sub_a = v_q;
			sub_b = r_q + bit_q;
		end else begin
			sub_a = {16'd0, v_q[pidvl_pkg::DEN_W-1:0], bit_q[pidvl_pkg::QUO_W-1]};
			sub_b = {17'd0, den_q};
		end
		diff = {1'b0, sub_a} - {1'b0, sub_b};
		ge   = !diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= ctl.sqrt_mode ? 5'd17 : 5'd16;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.sqrt_mode;
			r_q    <= '0;
			den_q  <= den;
			if (ctl.sqrt_mode) begin
				v_q   <= {1'b0, num};
				bit_q <= W'(1) << 32;
			end else begin
				v_q   <= W'(num[pidvl_pkg::SQ_W-1:pidvl_pkg::QUO_W]);
				bit_q <= W'(num[pidvl_pkg::QUO_W-1:0]);
			end
		end else if (run_q) begin
			if (mode_q) begin
				if (ge) begin
					v_q <= diff[W-1:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				v_q   <= ge ? diff[W-1:0] : sub_a;
				bit_q <= bit_q << 1;
				r_q   <= {r_q[W-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign root = r_q[pidvl_pkg::ROOT_W-1:0];
	assign quo  = r_q[pidvl_pkg::QUO_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/dual_axis_pid_velocity_limiter.sv =====
// Top level: dual-axis PID velocity commander with vector step limiter.
// Depends on pidvl_pkg, pidvl_if, pidvl_mac, pidvl_iter.
//
//  port    | dir | beat contents
//  --------+-----+------------------------------------------------------
//  in_ch   | in  | err_east, err_north, meas_vel_east/north, clear
//  out_ch  | out | cmd_vel_east, cmd_vel_north, accel_limited
//  cfg_*   | in  | write enable, register index, 16-bit data
//
// One beat at a time: the result is registered after the PID terms of both
// axes (skipped on a clear tick) and, when the step limit applies, after the
// root and the two divides; ready returns as the result is registered.
// The shared 18x18 multiplier gives one product a cycle and the root/divide
// unit resolves one bit per cycle.
// in_ch.ready is high only while idle; a finished result sits in the
// output register so the next beat can be taken while it waits.
// Reset clears control, integrals and previous errors and loads the
// register defaults.
`default_nettype none
module dual_axis_pid_velocity_limiter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	pidvl_in_if.sink                                in_ch,
	pidvl_out_if.source                             out_ch,
	input  wire logic                               cfg_we,
	input  wire logic [pidvl_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [pidvl_pkg::GAIN_W-1:0]       cfg_data
);
	typedef enum logic [15:0] {
		ST_IDLE = 16'h0001,
		ST_AXIS = 16'h0002,
		ST_MD   = 16'h0004,
		ST_MI   = 16'h0008,
		ST_MA   = 16'h0010,
		ST_RND  = 16'h0020,
		ST_DVX  = 16'h0040,
		ST_SQX  = 16'h0080,
		ST_SQY  = 16'h0100,
		ST_SQL  = 16'h0200,
		ST_CMP  = 16'h0400,
		ST_SQRT = 16'h0800,
		ST_MULX = 16'h1000,
		ST_DIVS = 16'h2000,
		ST_DIV  = 16'h4000,
		ST_DONE = 16'h8000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [pidvl_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [pidvl_pkg::LIM_W-1:0]  vel_lim_q, integ_lim_q, max_step_q;

	// tick operands and loop state
	logic signed [15:0] err_e_q, err_n_q, mv_e_q, mv_n_q;
	logic signed [15:0] integ_e_q, integ_n_q, prev_e_q, prev_n_q;
	logic signed [16:0] d_q;
	logic signed [15:0] ce_q, cn_q;
	logic signed [17:0] dvx_q, dvy_q;
	logic [pidvl_pkg::ROOT_W-1:0] dv_q;
	logic               axis_q;
	logic               limited_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] out_ce_q, out_cn_q;
	logic               out_lim_q;

	logic in_fire;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;

	// current-axis selects
	logic signed [15:0] e_cur, integ_cur, prev_cur, mv_cur;
	logic signed [17:0] dv_axis;
	logic [16:0]        dv_abs;
	assign e_cur     = axis_q ? err_n_q : err_e_q;
	assign integ_cur = axis_q ? integ_n_q : integ_e_q;
	assign prev_cur  = axis_q ? prev_n_q : prev_e_q;
	assign mv_cur    = axis_q ? mv_n_q : mv_e_q;
	assign dv_axis   = axis_q ? dvy_q : dvx_q;
	assign dv_abs    = dv_axis[17] ? 17'(-dv_axis) : dv_axis[16:0];

	// integral update, saturated to +-integral_limit
	logic signed [16:0] integ_sum, ilim_pos;
	logic signed [15:0] integ_new;
	always_comb begin
		integ_sum = 17'(integ_cur) + 17'(e_cur);
		ilim_pos  = {2'b00, integ_lim_q};
		if (integ_sum > ilim_pos) begin
			integ_new = ilim_pos[15:0];
		end else if (integ_sum < -ilim_pos) begin
			integ_new = 16'(-ilim_pos);
		end else begin
			integ_new = integ_sum[15:0];
		end
	end

	// shared multiply-accumulate
	pidvl_pkg::mac_ctl_t                  mac_ctl;
	logic signed [pidvl_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic signed [pidvl_pkg::PROD_W-1:0]  prod;
	logic signed [pidvl_pkg::ACC_W-1:0]   acc;

	pidvl_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.acc    (acc)
	);

	// round Q.20 sum to Q8.8 (half up) and clamp to +-vel_limit
	logic signed [pidvl_pkg::ACC_W-1:0] acc_rnd;
	logic signed [25:0]                 pid_sh, vlim_pos;
	logic signed [15:0]                 pid_cmd;
	always_comb begin
		acc_rnd  = acc + pidvl_pkg::ACC_W'(2048);
		pid_sh   = acc_rnd[pidvl_pkg::ACC_W-1:12];
		vlim_pos = 26'(vel_lim_q);
		if (pid_sh > vlim_pos) begin
			pid_cmd = vlim_pos[15:0];
		end else if (pid_sh < -vlim_pos) begin
			pid_cmd = 16'(-vlim_pos);
		end else begin
			pid_cmd = pid_sh[15:0];
		end
	end

	// root and divide unit
	pidvl_pkg::iter_ctl_t               it_ctl;
	logic [pidvl_pkg::SQ_W-1:0]         it_num;
	logic [pidvl_pkg::DEN_W-1:0]        it_den;
	logic                               it_done;
	logic [pidvl_pkg::ROOT_W-1:0]       it_root;
	logic [pidvl_pkg::QUO_W-1:0]        it_quo;

	pidvl_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (it_ctl),
		.num    (it_num),
		.den    (it_den),
		.done   (it_done),
		.root   (it_root),
		.quo    (it_quo)
	);

	// limited command: meas +- quotient, saturated to 16 bits
	logic signed [17:0] lim_sum;
	logic signed [15:0] lim_cmd;
	always_comb begin
		lim_sum = dv_axis[17] ? 18'(mv_cur) - 18'(it_quo) : 18'(mv_cur) + 18'(it_quo);
		if (lim_sum > 18'sd32767) begin
			lim_cmd = 16'sh7fff;
		end else if (lim_sum < -18'sd32768) begin
			lim_cmd = 16'sh8000;
		end else begin
			lim_cmd = lim_sum[15:0];
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ch.ready;

	// sequencer controls
	always_comb begin
		state_d          = state_q;
		mac_ctl.mul_en   = 1'b0;
		mac_ctl.acc_op   = pidvl_pkg::ACC_HOLD;
		mul_a            = '0;
		mul_b            = '0;
		it_ctl.start     = 1'b0;
		it_ctl.sqrt_mode = 1'b0;
		it_num           = acc[pidvl_pkg::SQ_W-1:0];
		it_den           = {dv_q, 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = in_ch.clear ? ST_DVX : ST_AXIS;
				end
			end
			ST_AXIS: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = {2'b00, kp_q};
				mul_b          = 18'(e_cur);
				state_d        = ST_MD;
			end
			ST_MD: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = pidvl_pkg::ACC_LOAD;
				mul_a          = {2'b00, kd_q};
				mul_b          = 18'(d_q);
				state_d        = ST_MI;
			end
			ST_MI: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = pidvl_pkg::ACC_ADD;
				mul_a          = {2'b00, ki_q};
				mul_b          = 18'(integ_cur);
				state_d        = ST_MA;
			end
			ST_MA: begin
				mac_ctl.acc_op = pidvl_pkg::ACC_ADD;
				state_d        = ST_RND;
			end
			ST_RND: begin
				state_d = axis_q ? ST_DVX : ST_AXIS;
			end
			ST_DVX: begin
				state_d = ST_SQX;
			end
			ST_SQX: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = dvx_q;
				mul_b          = dvx_q;
				state_d        = ST_SQY;
			end
			ST_SQY: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = pidvl_pkg::ACC_LOAD;
				mul_a          = dvy_q;
				mul_b          = dvy_q;
				state_d        = ST_SQL;
			end
			ST_SQL: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_op = pidvl_pkg::ACC_ADD;
				mul_a          = {3'b000, max_step_q};
				mul_b          = {3'b000, max_step_q};
				state_d        = ST_CMP;
			end
			ST_CMP: begin
				// acc holds dvx^2 + dvy^2, prod holds max_step^2
				if (acc > pidvl_pkg::ACC_W'(prod)) begin
					it_ctl.start     = 1'b1;
					it_ctl.sqrt_mode = 1'b1;
					state_d          = ST_SQRT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SQRT: begin
				if (it_done) begin
					state_d = ST_MULX;
				end
			end
			ST_MULX: begin
				mac_ctl.mul_en = 1'b1;
				mul_a          = {1'b0, dv_abs};
				mul_b          = {3'b000, max_step_q};
				state_d        = ST_DIVS;
			end
			ST_DIVS: begin
				// q = (2*|dv_axis|*max_step + dv) / (2*dv)
				it_ctl.start = 1'b1;
				it_num       = {prod[pidvl_pkg::SQ_W-3:0], 1'b0}
					+ pidvl_pkg::SQ_W'(dv_q);
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				if (it_done) begin
					state_d = axis_q ? ST_DONE : ST_MULX;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= pidvl_pkg::KP_RST;
			ki_q        <= pidvl_pkg::KI_RST;
			kd_q        <= pidvl_pkg::KD_RST;
			vel_lim_q   <= pidvl_pkg::VEL_LIM_RST;
			integ_lim_q <= pidvl_pkg::INTEG_LIM_RST;
			max_step_q  <= pidvl_pkg::MAX_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pidvl_pkg::REG_KP:        kp_q        <= cfg_data;
				pidvl_pkg::REG_KI:        ki_q        <= cfg_data;
				pidvl_pkg::REG_KD:        kd_q        <= cfg_data;
				pidvl_pkg::REG_VEL_LIM:   vel_lim_q   <= cfg_data[pidvl_pkg::LIM_W-1:0];
				pidvl_pkg::REG_INTEG_LIM: integ_lim_q <= cfg_data[pidvl_pkg::LIM_W-1:0];
				pidvl_pkg::REG_MAX_STEP:  max_step_q  <= cfg_data[pidvl_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// loop state: integrals and previous errors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_e_q <= '0;
			integ_n_q <= '0;
			prev_e_q  <= '0;
			prev_n_q  <= '0;
		end else if (in_fire && in_ch.clear) begin
			// clear tick keeps the previous errors
			integ_e_q <= '0;
			integ_n_q <= '0;
		end else if (state_q == ST_AXIS) begin
			if (axis_q) begin
				integ_n_q <= integ_new;
				prev_n_q  <= e_cur;
			end else begin
				integ_e_q <= integ_new;
				prev_e_q  <= e_cur;
			end
		end
	end

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q    <= 1'b0;
			limited_q <= 1'b0;
		end else begin
			if (in_fire) begin
				axis_q    <= 1'b0;
				limited_q <= 1'b0;
			end else if (state_q == ST_RND || state_q == ST_SQRT && it_done) begin
				axis_q <= !axis_q && state_q == ST_RND;
			end else if (state_q == ST_DIV && it_done) begin
				axis_q    <= 1'b1;
				limited_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_e_q <= in_ch.err_east;
			err_n_q <= in_ch.err_north;
			mv_e_q  <= in_ch.meas_vel_east;
			mv_n_q  <= in_ch.meas_vel_north;
			ce_q    <= '0;
			cn_q    <= '0;
		end
		if (state_q == ST_AXIS) begin
			d_q <= 17'(e_cur) - 17'(prev_cur);
		end
		if (state_q == ST_RND) begin
			if (axis_q) begin
				cn_q <= pid_cmd;
			end else begin
				ce_q <= pid_cmd;
			end
		end
		if (state_q == ST_DVX) begin
			dvx_q <= 18'(ce_q) - 18'(mv_e_q);
			dvy_q <= 18'(cn_q) - 18'(mv_n_q);
		end
		if (state_q == ST_SQRT && it_done) begin
			dv_q <= (it_root == '0) ? pidvl_pkg::ROOT_W'(1) : it_root;
		end
		if (state_q == ST_DIV && it_done) begin
			if (axis_q) begin
				cn_q <= lim_cmd;
			end else begin
				ce_q <= lim_cmd;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_ce_q  <= ce_q;
			out_cn_q  <= cn_q;
			out_lim_q <= limited_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.cmd_vel_east  = out_ce_q;
	assign out_ch.cmd_vel_north = out_cn_q;
	assign out_ch.accel_limited = out_lim_q;
endmodule
`default_nettype wire

// ===== rtl/pidvl_checker.sv =====
// Port-level checks for the PID velocity limiter, bound to the top level.
// Depends on assert_macros.svh and the top level's ports.
`default_nettype none
`include "assert_macros.svh"
module pidvl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_east,
	input wire logic [15:0] out_north,
	input wire logic        out_lim
);
	logic       in_fire, out_fire;
	logic [1:0] pend_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_fire && !out_fire) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_fire && !in_fire) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`PIDVL_ASSERT(a_busy_after_accept, clk, arst_n, in_fire |=> !in_ready)
	`PIDVL_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_east) && $stable(out_north) && $stable(out_lim))
	`PIDVL_ASSERT_MSG(a_no_phantom, clk, arst_n, out_valid |-> pend_q != 2'd0, "result without a tick")
	`PIDVL_ASSERT_MSG(a_pend_bound, clk, arst_n, pend_q != 2'd3, "more than two ticks in flight")
endmodule

bind dual_axis_pid_velocity_limiter pidvl_checker u_pidvl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_east  (out_ch.cmd_vel_east),
	.out_north (out_ch.cmd_vel_north),
	.out_lim   (out_ch.accel_limited)
);
`default_nettype wire
